### rtl/ppmd_pkg.sv
package ppmd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int DIST_W      = 52;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int MUL_W    = COORD_WIDTH + 3;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DOT_W    = 2 * DIFF_W + 1;
    localparam int LSQ_W    = 2 * DIFF_W;
    localparam int T_W      = T_FRAC_BITS + 1;
    localparam int RND_W    = DIFF_W + 1;
    localparam int CX_W     = COORD_WIDTH + 3;
    localparam int DX_W     = COORD_WIDTH + 4;
    localparam int MAG_W    = 26;
    localparam int CNT_W    = $clog2(T_FRAC_BITS + 1);

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [T_W-1:0]    T_ONE    = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [PROD_W-1:0] T_HALF =
        {{(PROD_W - T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS - 1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] query_x;
        logic signed [COORD_WIDTH-1:0] query_y;
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic                          vertex_valid;
        logic                          first_vertex;
        logic                          last_vertex;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] nearest_sq;
        logic              empty_line;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIFF,
        OP_DOT,
        OP_LEN,
        OP_LSQ,
        OP_CLAMP,
        OP_DIV,
        OP_NEAR,
        OP_CPT,
        OP_DXS,
        OP_SQ,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic new_vertex;
        logic new_last;
        logic last;
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/ppmd_div.sv
module ppmd_div
    import ppmd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             step,
    input  logic [LSQ_W-1:0] num,
    input  logic [LSQ_W-1:0] den,
    output logic [T_W-1:0]   quot,
    output logic             last_step
);

    logic [LSQ_W-1:0]       rem_reg, rem_next;
    logic [LSQ_W-1:0]       den_reg, den_next;
    logic [T_FRAC_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [LSQ_W:0] shifted;
    logic [LSQ_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
        end
        else if (step)
        begin
            rem_next  = ge ? diff[LSQ_W-1:0] : shifted[LSQ_W-1:0];
            quot_next = {quot_reg[T_FRAC_BITS-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot      = {1'b0, quot_reg};
    assign last_step = cnt_reg == CNT_W'(T_FRAC_BITS - 1);

endmodule

### rtl/ppmd_dp.sv
module ppmd_dp
    import ppmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  item_t   item,
    input  logic    result_stall,
    output sts_t    sts,
    output logic    result_valid,
    output result_t result
);

    logic signed [COORD_WIDTH-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [COORD_WIDTH-1:0] prevx_reg, prevx_next, prevy_reg, prevy_next;
    logic signed [COORD_WIDTH-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [COORD_WIDTH-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [DIFF_W-1:0]      abx_reg, abx_next, aby_reg, aby_next;
    logic signed [DIFF_W-1:0]      apx_reg, apx_next, apy_reg, apy_next;
    logic signed [PROD_W-1:0]      prodx_reg, prodx_next, prody_reg, prody_next;
    logic signed [DOT_W-1:0]       dot_reg, dot_next;
    logic [LSQ_W-1:0]              lsq_reg, lsq_next;
    logic [T_W-1:0]                t_reg, t_next;
    logic                          use_div_reg, use_div_next;
    logic signed [CX_W-1:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic [MAG_W-1:0]              magx_reg, magx_next, magy_reg, magy_next;
    logic                          satx_reg, satx_next, saty_reg, saty_next;
    logic [DIST_W-1:0]             min_reg, min_next;
    logic [1:0]                    seen_reg, seen_next;
    logic                          last_reg, last_next;
    result_t                       out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [MUL_W-1:0]  mul_ax, mul_bx, mul_ay, mul_by;
    logic signed [PROD_W-1:0] mul_x, mul_y;
    logic [T_W-1:0]           t_sel;
    logic [T_W-1:0]           div_quot;
    logic                     div_last;
    logic                     ab_zero, dot_pos, dot_ge, need_div;
    logic signed [PROD_W-1:0] rsum_x, rsum_y, rsh_x, rsh_y;
    logic signed [RND_W-1:0]  rnd_x, rnd_y;
    logic signed [DX_W-1:0]   dx, dy;
    logic [DX_W-1:0]          absx, absy;
    logic [DIST_W-1:0]        sqx, sqy;
    logic [DIST_W:0]          dsum;
    logic [DIST_W-1:0]        seg_sq;
    logic                     seen0;
    logic                     out_free;

    assign seen0 = seen_reg == 2'd0;
    assign t_sel = use_div_reg ? div_quot : t_reg;

    assign ab_zero  = (abx_reg == '0) && (aby_reg == '0);
    assign dot_pos  = !dot_reg[DOT_W-1] && (dot_reg != '0);
    assign dot_ge   = $unsigned(dot_reg) >= {1'b0, lsq_reg};
    assign need_div = !ab_zero && dot_pos && !dot_ge;

    ppmd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.op == OP_CLAMP),
        .step      (cmd.op == OP_DIV),
        .num       (dot_reg[LSQ_W-1:0]),
        .den       (lsq_reg),
        .quot      (div_quot),
        .last_step (div_last)
    );

    always_comb
    begin
        unique case (cmd.op)
            OP_DOT:
            begin
                mul_ax = MUL_W'(apx_reg);
                mul_bx = MUL_W'(abx_reg);
                mul_ay = MUL_W'(apy_reg);
                mul_by = MUL_W'(aby_reg);
            end
            OP_NEAR:
            begin
                mul_ax = MUL_W'(abx_reg);
                mul_bx = MUL_W'(t_sel);
                mul_ay = MUL_W'(aby_reg);
                mul_by = MUL_W'(t_sel);
            end
            OP_SQ:
            begin
                mul_ax = MUL_W'(magx_reg);
                mul_bx = MUL_W'(magx_reg);
                mul_ay = MUL_W'(magy_reg);
                mul_by = MUL_W'(magy_reg);
            end
            default:
            begin
                mul_ax = MUL_W'(abx_reg);
                mul_bx = MUL_W'(abx_reg);
                mul_ay = MUL_W'(aby_reg);
                mul_by = MUL_W'(aby_reg);
            end
        endcase
    end

    assign mul_x = mul_ax * mul_bx;
    assign mul_y = mul_ay * mul_by;

    assign rsum_x = prodx_reg + T_HALF;
    assign rsum_y = prody_reg + T_HALF;
    assign rsh_x  = rsum_x >>> T_FRAC_BITS;
    assign rsh_y  = rsum_y >>> T_FRAC_BITS;
    assign rnd_x  = rsh_x[RND_W-1:0];
    assign rnd_y  = rsh_y[RND_W-1:0];

    assign dx   = DX_W'(qx_reg) - DX_W'(cx_reg);
    assign dy   = DX_W'(qy_reg) - DX_W'(cy_reg);
    assign absx = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    assign absy = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);

    assign sqx    = satx_reg ? DIST_MAX : prodx_reg[DIST_W-1:0];
    assign sqy    = saty_reg ? DIST_MAX : prody_reg[DIST_W-1:0];
    assign dsum   = {1'b0, sqx} + {1'b0, sqy};
    assign seg_sq = dsum[DIST_W] ? DIST_MAX : dsum[DIST_W-1:0];

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        prevx_next     = prevx_reg;
        prevy_next     = prevy_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        abx_next       = abx_reg;
        aby_next       = aby_reg;
        apx_next       = apx_reg;
        apy_next       = apy_reg;
        prodx_next     = prodx_reg;
        prody_next     = prody_reg;
        dot_next       = dot_reg;
        lsq_next       = lsq_reg;
        t_next         = t_reg;
        use_div_next   = use_div_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        magx_next      = magx_reg;
        magy_next      = magy_reg;
        satx_next      = satx_reg;
        saty_next      = saty_reg;
        min_next       = min_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        unique case (cmd.op)
            OP_ACCEPT:
            begin
                if (item.first_vertex)
                begin
                    qx_next   = item.query_x;
                    qy_next   = item.query_y;
                    seen_next = 2'd0;
                    min_next  = DIST_MAX;
                end
                vx_next   = item.vertex_x;
                vy_next   = item.vertex_y;
                last_next = item.last_vertex;
            end
            OP_DIFF:
            begin
                ax_next  = seen0 ? vx_reg : prevx_reg;
                ay_next  = seen0 ? vy_reg : prevy_reg;
                abx_next = seen0 ? '0 : DIFF_W'(vx_reg) - DIFF_W'(prevx_reg);
                aby_next = seen0 ? '0 : DIFF_W'(vy_reg) - DIFF_W'(prevy_reg);
                apx_next = DIFF_W'(qx_reg) - (seen0 ? DIFF_W'(vx_reg) : DIFF_W'(prevx_reg));
                apy_next = DIFF_W'(qy_reg) - (seen0 ? DIFF_W'(vy_reg) : DIFF_W'(prevy_reg));
            end
            OP_DOT, OP_NEAR, OP_SQ:
            begin
                prodx_next = mul_x;
                prody_next = mul_y;
            end
            OP_LEN:
            begin
                dot_next   = DOT_W'($signed(prodx_reg[LSQ_W-1:0]))
                           + DOT_W'($signed(prody_reg[LSQ_W-1:0]));
                prodx_next = mul_x;
                prody_next = mul_y;
            end
            OP_LSQ:
            begin
                lsq_next = prodx_reg[LSQ_W-1:0] + prody_reg[LSQ_W-1:0];
            end
            OP_CLAMP:
            begin
                t_next       = (ab_zero || !dot_pos) ? '0 : T_ONE;
                use_div_next = need_div;
            end
            OP_CPT:
            begin
                cx_next = CX_W'(ax_reg) + CX_W'(rnd_x);
                cy_next = CX_W'(ay_reg) + CX_W'(rnd_y);
            end
            OP_DXS:
            begin
                magx_next = absx[MAG_W-1:0];
                magy_next = absy[MAG_W-1:0];
                satx_next = absx[DX_W-1:MAG_W] != '0;
                saty_next = absy[DX_W-1:MAG_W] != '0;
            end
            OP_ACC:
            begin
                if (seen0)
                begin
                    min_next  = seg_sq;
                    seen_next = 2'd1;
                end
                else
                begin
                    if (seen_reg == 2'd1 || seg_sq < min_reg)
                    begin
                        min_next = seg_sq;
                    end
                    seen_next = 2'd2;
                end
                prevx_next = vx_reg;
                prevy_next = vy_reg;
            end
            OP_EMIT:
            begin
                out_next.nearest_sq = seen0 ? DIST_MAX : min_reg;
                out_next.empty_line = seen0;
                out_valid_next      = 1'b1;
                seen_next           = 2'd0;
                min_next            = DIST_MAX;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg        <= '0;
            qy_reg        <= '0;
            prevx_reg     <= '0;
            prevy_reg     <= '0;
            min_reg       <= DIST_MAX;
            seen_reg      <= 2'd0;
            use_div_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            qx_reg        <= qx_next;
            qy_reg        <= qy_next;
            prevx_reg     <= prevx_next;
            prevy_reg     <= prevy_next;
            min_reg       <= min_next;
            seen_reg      <= seen_next;
            use_div_reg   <= use_div_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        abx_reg   <= abx_next;
        aby_reg   <= aby_next;
        apx_reg   <= apx_next;
        apy_reg   <= apy_next;
        prodx_reg <= prodx_next;
        prody_reg <= prody_next;
        dot_reg   <= dot_next;
        lsq_reg   <= lsq_next;
        t_reg     <= t_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        magx_reg  <= magx_next;
        magy_reg  <= magy_next;
        satx_reg  <= satx_next;
        saty_reg  <= saty_next;
        last_reg  <= last_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        sts.new_vertex = item.vertex_valid;
        sts.new_last   = item.last_vertex;
        sts.last       = last_reg;
        sts.need_div   = need_div;
        sts.div_last   = div_last;
        sts.out_free   = out_free;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/ppmd_ctrl.sv
module ppmd_ctrl
    import ppmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  sts_t sts,
    output logic item_stall,
    output cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DIFF  = 13'b0000000000010,
        S_DOT   = 13'b0000000000100,
        S_LEN   = 13'b0000000001000,
        S_LSQ   = 13'b0000000010000,
        S_CLAMP = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_NEAR  = 13'b0000010000000,
        S_CPT   = 13'b0000100000000,
        S_DXS   = 13'b0001000000000,
        S_SQ    = 13'b0010000000000,
        S_ACC   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    if (sts.new_vertex)
                    begin
                        state_next = S_DIFF;
                    end
                    else if (sts.new_last)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_DOT;
            end
            S_DOT:
            begin
                cmd.op     = OP_DOT;
                state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.op     = OP_LEN;
                state_next = S_LSQ;
            end
            S_LSQ:
            begin
                cmd.op     = OP_LSQ;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                state_next = sts.need_div ? S_DIV : S_NEAR;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (sts.div_last)
                begin
                    state_next = S_NEAR;
                end
            end
            S_NEAR:
            begin
                cmd.op     = OP_NEAR;
                state_next = S_CPT;
            end
            S_CPT:
            begin
                cmd.op     = OP_CPT;
                state_next = S_DXS;
            end
            S_DXS:
            begin
                cmd.op     = OP_DXS;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = state_reg != S_IDLE;

endmodule

### rtl/point_polyline_min_distance_sq.sv
// Least squared distance from a query point to a polyline.
// Input channel (item_valid, item_stall, item): one word per vertex. The word
// marked first_vertex latches the query point; the word marked last_vertex
// closes the polyline. A word with vertex_valid low carries no vertex and
// only acts on its first and last marks (an empty polyline).
// Output channel (result_valid, result_stall, result): one word per polyline,
// nearest_sq an unsigned integer, empty_line set for an empty polyline.
// Each vertex is accepted in IDLE and then steps through DIFF, DOT, LEN, LSQ,
// CLAMP, NEAR, CPT, DXS, SQ and ACC; when the projection parameter is
// strictly inside the segment, DIV follows CLAMP, where the restoring divider
// retires one quotient bit per cycle. A word without a vertex is taken in
// IDLE and goes on to EMIT when it closes the polyline. The result is written
// to an output register in EMIT, so the next polyline is taken in while it
// waits. A stalled receiver holds the result; the block only halts when a
// second result is ready before the first is taken.
// Reset clears the query point and previous vertex to zero and starts a new
// polyline with no vertices seen.
module point_polyline_min_distance_sq
    import ppmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cmd_t cmd;
    sts_t sts;

    ppmd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .sts        (sts),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    ppmd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result_stall (result_stall),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### bench/testbench.sv
module testbench;
    import ppmd_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam longint unsigned DIST_CAP = (longint'(1) << DIST_W) - 1;
    localparam longint T_UNIT = longint'(1) << T_FRAC_BITS;
    localparam longint T_MID = T_UNIT >> 1;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_CAP = 200;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    point_polyline_min_distance_sq dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor state
    longint          query_x_q;
    longint          query_y_q;
    longint          prev_x_q;
    longint          prev_y_q;
    longint unsigned best_dist;
    int              vertex_count;
    result_t         distances_due[$];

    int   errors = 0;
    int   words_sent = 0;
    int   polylines_closed = 0;
    int   empty_closed = 0;
    int   results_checked = 0;
    int   input_held_cycles = 0;
    bit   feed_steady = 1'b0;
    bit   sink_quiet = 1'b0;
    bit   hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic longint unsigned square_sat(longint d);
        longint m;
        m = (d < 0) ? -d : d;
        if (m > longint'(64'h3FF_FFFF))
            return DIST_CAP;
        return longint'(m * m);
    endfunction

    function automatic longint unsigned pair_dist(longint dx, longint dy);
        longint unsigned s;
        s = square_sat(dx) + square_sat(dy);
        return (s > DIST_CAP) ? DIST_CAP : s;
    endfunction

    function automatic longint unsigned segment_dist(longint px, longint py,
                                                     longint ax, longint ay,
                                                     longint bx, longint by);
        longint abx, aby, apx, apy, dot, lsq, t, cx, cy;
        longint unsigned rem, quo, den;
        int i;
        abx = bx - ax;
        aby = by - ay;
        if (abx == 0 && aby == 0)
            return pair_dist(px - ax, py - ay);
        apx = px - ax;
        apy = py - ay;
        dot = apx * abx + apy * aby;
        lsq = abx * abx + aby * aby;
        if (dot <= 0)
            t = 0;
        else if (dot >= lsq)
            t = T_UNIT;
        else
        begin
            rem = dot;
            den = lsq;
            quo = 0;
            for (i = 0; i < T_FRAC_BITS; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo = quo | 1;
                end
            end
            t = longint'(quo);
        end
        cx = ax + ((abx * t + T_MID) >>> T_FRAC_BITS);
        cy = ay + ((aby * t + T_MID) >>> T_FRAC_BITS);
        return pair_dist(px - cx, py - cy);
    endfunction

    task automatic polyline_step(input item_t w);
        longint vx, vy;
        longint unsigned d;
        result_t r;
        if (w.first_vertex)
        begin
            query_x_q = w.query_x;
            query_y_q = w.query_y;
            vertex_count = 0;
            best_dist = DIST_CAP;
        end
        if (w.vertex_valid)
        begin
            vx = w.vertex_x;
            vy = w.vertex_y;
            if (vertex_count == 0)
            begin
                best_dist = pair_dist(query_x_q - vx, query_y_q - vy);
                vertex_count = 1;
            end
            else
            begin
                d = segment_dist(query_x_q, query_y_q, prev_x_q, prev_y_q, vx, vy);
                if (vertex_count == 1 || d < best_dist)
                    best_dist = d;
                vertex_count = 2;
            end
            prev_x_q = vx;
            prev_y_q = vy;
        end
        if (w.last_vertex)
        begin
            r.empty_line = (vertex_count == 0);
            r.nearest_sq = (vertex_count == 0) ? DIST_MAX : best_dist[DIST_W-1:0];
            distances_due = {distances_due, r};
            polylines_closed++;
            if (vertex_count == 0)
                empty_closed++;
            vertex_count = 0;
            best_dist = DIST_CAP;
        end
    endtask

    function automatic item_t make_word(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                                        logic valid, logic first_mark, logic last_mark);
        item_t w;
        w.query_x = qx;
        w.query_y = qy;
        w.vertex_x = vx;
        w.vertex_y = vy;
        w.vertex_valid = valid;
        w.first_vertex = first_mark;
        w.last_vertex = last_mark;
        return w;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic coord_t coord_near(coord_t c, int span);
        return coord_t'(c + ($urandom_range(0, 2 * span) - span));
    endfunction

    task automatic send_word(input item_t w);
        int gap;
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        polyline_step(w);
        words_sent++;
        if (feed_steady || $urandom_range(0, 9) < 6)
            gap = 0;
        else
            gap = idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (distances_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin : sink_drive
        int hold_left;
        int stall_left;
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!sink_quiet && $urandom_range(0, 3) == 0)
        begin
            stall_left = idle_len() - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && item_valid && item_stall === 1'b1)
            input_held_cycles++;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            results_checked++;
            if (distances_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result dist=%h empty=%b", $time,
                             result.nearest_sq, result.empty_line);
            end
            else
            begin
                want = distances_due.pop_front();
                if (result.nearest_sq !== want.nearest_sq ||
                    result.empty_line !== want.empty_line)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: expected dist=%h empty=%b, got dist=%h empty=%b",
                                 $time, want.nearest_sq, want.empty_line,
                                 result.nearest_sq, result.empty_line);
                end
            end
        end
    end

    task automatic test_directed_cases();
        // empty line, then one far vertex at opposite corners
        send_word(make_word(0, 0, 0, 0, 1'b0, 1'b1, 1'b1));
        send_word(make_word(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, 1'b1, 1'b1));
        // zero-length segment, then a full-span segment
        send_word(make_word(C_MAX, C_MIN, C_MIN, C_MAX, 1'b1, 1'b1, 1'b0));
        send_word(make_word(0, 0, C_MIN, C_MAX, 1'b1, 1'b0, 1'b0));
        send_word(make_word(0, 0, C_MAX, C_MIN, 1'b1, 1'b0, 1'b1));
        // no first mark: keep the old query; ignored word in the middle
        send_word(make_word(123, 456, 0, 0, 1'b1, 1'b0, 1'b0));
        send_word(make_word(C_MAX, C_MAX, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0));
        send_word(make_word(0, 0, 16, 0, 1'b1, 1'b0, 1'b1));
        // projection before the start, strictly inside, dot of zero, at the end
        send_word(make_word(0, 0, 16, 16, 1'b1, 1'b1, 1'b0));
        send_word(make_word(0, 0, 32, 32, 1'b1, 1'b0, 1'b0));
        send_word(make_word(0, 0, -32, -32, 1'b1, 1'b0, 1'b0));
        send_word(make_word(0, 0, -32, 64, 1'b1, 1'b0, 1'b0));
        send_word(make_word(0, 0, 32, 96, 1'b1, 1'b0, 1'b0));
        send_word(make_word(0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
        // close a non-empty line with a word carrying no vertex
        send_word(make_word(0, 0, 7, 7, 1'b0, 1'b0, 1'b1));
        // restart in the middle of a line
        send_word(make_word(5, -7, C_MIN, C_MIN, 1'b1, 1'b1, 1'b0));
        send_word(make_word(0, 0, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0));
        send_word(make_word(-100, 100, 100, -100, 1'b1, 1'b1, 1'b0));
        send_word(make_word(0, 0, -100, 100, 1'b1, 1'b0, 1'b1));
        // first mark without a vertex, then close empty
        send_word(make_word(C_MAX, C_MAX, 0, 0, 1'b0, 1'b1, 1'b0));
        send_word(make_word(0, 0, 0, 0, 1'b0, 1'b0, 1'b1));
        // first and last on one vertex
        send_word(make_word(-1, -1, 1, 1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(C_MIN, C_MAX, C_MIN, C_MAX, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_random_polylines(input int budget);
        int sent, n, k, pick, span, phase_mark;
        bit near_mode;
        coord_t qx, qy, vx, vy, px, py;
        sent = 0;
        phase_mark = 0;
        px = '0;
        py = '0;
        while (sent < budget)
        begin
            if (sent - phase_mark >= 150)
            begin
                phase_mark = sent;
                if ($urandom_range(0, 2) == 0)
                    settle();
                feed_steady = ($urandom_range(0, 3) == 0);
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(make_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                    $urandom_range(0, 1), $urandom_range(0, 1),
                                    $urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    n = 0;
                else if (pick < 75)
                    n = $urandom_range(1, 6);
                else if (pick < 95)
                    n = $urandom_range(7, 12);
                else
                    n = $urandom_range(13, 30);
                qx = rand_coord();
                qy = rand_coord();
                near_mode = ($urandom_range(0, 2) != 0);
                case ($urandom_range(0, 2))
                    0: span = 64;
                    1: span = 4096;
                    default: span = 1 << 20;
                endcase
                if (n == 0)
                begin
                    send_word(make_word(qx, qy, rand_coord(), rand_coord(),
                                        1'b0, 1'b1, 1'b1));
                    sent++;
                end
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(make_word(rand_coord(), rand_coord(), rand_coord(),
                                            rand_coord(), 1'b0, 1'b0, 1'b0));
                    if (k > 0 && $urandom_range(0, 19) == 0)
                    begin
                        vx = px;
                        vy = py;
                    end
                    else if (near_mode)
                    begin
                        vx = coord_near(qx, span);
                        vy = coord_near(qy, span);
                    end
                    else
                    begin
                        vx = rand_coord();
                        vy = rand_coord();
                    end
                    send_word(make_word((k == 0) ? qx : rand_coord(),
                                        (k == 0) ? qy : rand_coord(),
                                        vx, vy, 1'b1, k == 0, k == n - 1));
                    px = vx;
                    py = vy;
                    sent++;
                end
            end
        end
        feed_steady = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task automatic test_output_held();
        int n, k;
        coord_t qx, qy;
        feed_steady = 1'b1;
        hold_req = 1'b1;
        repeat (60)
        begin
            qx = rand_coord();
            qy = rand_coord();
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++)
                send_word(make_word(qx, qy, coord_near(qx, 256), coord_near(qy, 256),
                                    1'b1, k == 0, k == n - 1));
        end
        feed_steady = 1'b0;
        settle();
    endtask

    initial
    begin
        vertex_count = 0;
        best_dist = DIST_CAP;
        query_x_q = 0;
        query_y_q = 0;
        prev_x_q = 0;
        prev_y_q = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        settle();
        test_random_polylines(1470);
        settle();
        test_output_held();
        $display("%0d words sent, %0d polylines closed (%0d empty), %0d results checked",
                 words_sent, polylines_closed, empty_closed, results_checked);
        $display("input held back for %0d cycles, %0d errors", input_held_cycles, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/ppmd_pkg.sv
rtl/ppmd_div.sv
rtl/ppmd_dp.sv
rtl/ppmd_ctrl.sv
rtl/point_polyline_min_distance_sq.sv
bench/testbench.sv
